@@ src/rational_arith_reduce_assert.svh @@
// Assertion macros used by the rational reduce controller.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define RAR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rar_pkg.sv @@
// Package: types, codes and constants of the rational reduce block.
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

    // Internal arithmetic width and divider counter width
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [WIDTH-1:0] W_MIN = {1'b1, {(WIDTH-1){1'b0}}};

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_WRAP  = 2'd1;
    localparam logic [1:0] STATUS_UNDEF = 2'd2;

    // Multiplier operand pair select
    localparam logic [2:0] MUL_LN_RD = 3'd0;
    localparam logic [2:0] MUL_RN_LD = 3'd1;
    localparam logic [2:0] MUL_LD_RD = 3'd2;
    localparam logic [2:0] MUL_LN_RN = 3'd3;
    localparam logic [2:0] MUL_LD_RN = 3'd4;

    // Divider dividend select
    localparam logic [1:0] DIV_REM  = 2'd0;
    localparam logic [1:0] DIV_QNUM = 2'd1;
    localparam logic [1:0] DIV_QDEN = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] lhs_num;
        logic signed [31:0] lhs_den;
        logic signed [31:0] rhs_num;
        logic signed [31:0] rhs_den;
    } rar_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic [1:0]         status;
    } rar_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       mul_go;
        logic [2:0] mul_sel;
        logic       wr_num;
        logic       wr_den;
        logic       add_go;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       num_q;
        logic       den_q;
        logic       out_load;
    } rar_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       den_zero;
        logic       rem_zero;
        logic       div_done;
        logic       div_busy;
    } rar_sts_t;

endpackage

`default_nettype wire

@@ src/rar_div.sv @@
// Bit-serial signed divider with truncating quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none

module rar_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rar_pkg::WIDTH-1:0] dividend,
    input  wire logic [rar_pkg::WIDTH-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [rar_pkg::WIDTH-1:0]      quotient,
    output logic [rar_pkg::WIDTH-1:0]      remainder
);
    import rar_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dm_reg, dm_next;
    logic             qneg_reg, qneg_next;
    logic             rneg_reg, rneg_next;

    logic [WIDTH:0]   shifted;
    logic             ge;

    // One restoring step per cycle on magnitudes
    always_comb
    begin
        shifted = {rem_reg, quo_reg[WIDTH-1]};
        ge      = (shifted >= {1'b0, dm_reg});
    end

    // Sequence start, iterate, finish
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dm_next   = dm_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
            dm_next   = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
            qneg_next = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            rneg_next = dividend[WIDTH-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? WIDTH'(shifted - {1'b0, dm_reg}) : shifted[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dm_reg   <= dm_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    // Apply signs to the magnitude results
    assign quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

@@ src/rar_dp.sv @@
// Datapath: operand registers, multiplier, adder, gcd registers and divider.
`timescale 1ns / 1ps
`default_nettype none

module rar_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rar_pkg::rar_in_t  in_data,
    input  wire rar_pkg::rar_cmd_t cmd,
    output rar_pkg::rar_sts_t      sts,
    output rar_pkg::rar_out_t      out_data
);
    import rar_pkg::*;

    logic [1:0]               op_reg;
    logic signed [WIDTH-1:0]  ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [WIDTH-1:0]  num_reg, den_reg;
    logic signed [WIDTH-1:0]  gx_reg, gy_reg;
    logic signed [2*WIDTH-1:0] prod_reg, prod_next;
    logic                     wr_reg;
    rar_out_t                 out_reg;

    logic signed [WIDTH-1:0]  ma, mb;
    logic                     prod_wrap;
    logic [WIDTH-1:0]         sum;
    logic                     add_ovf;
    logic [WIDTH-1:0]         div_a;
    logic                     div_busy, div_done;
    logic [WIDTH-1:0]         div_q, div_r;
    logic                     gy_neg_one;
    logic                     qn_wrap, qd_wrap;

    // Select multiplier operand pair
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LN_RD: begin ma = ln_reg; mb = rd_reg; end
            MUL_RN_LD: begin ma = rn_reg; mb = ld_reg; end
            MUL_LD_RD: begin ma = ld_reg; mb = rd_reg; end
            MUL_LN_RN: begin ma = ln_reg; mb = rn_reg; end
            MUL_LD_RN: begin ma = ld_reg; mb = rn_reg; end
            default:   begin ma = ln_reg; mb = rd_reg; end
        endcase
    end

    assign prod_next = ma * mb;

    // Product wraps unless its upper half is a pure sign extension
    assign prod_wrap = !((&prod_reg[2*WIDTH-1:WIDTH-1]) || !(|prod_reg[2*WIDTH-1:WIDTH-1]));

    // Add or subtract the two partial numerators
    always_comb
    begin
        if (op_reg == OP_SUB)
        begin
            sum     = num_reg - den_reg;
            add_ovf = (num_reg[WIDTH-1] != den_reg[WIDTH-1]) &&
                      (sum[WIDTH-1] != num_reg[WIDTH-1]);
        end
        else
        begin
            sum     = num_reg + den_reg;
            add_ovf = (num_reg[WIDTH-1] == den_reg[WIDTH-1]) &&
                      (sum[WIDTH-1] != num_reg[WIDTH-1]);
        end
    end

    // Select dividend
    always_comb
    begin
        case (cmd.div_sel)
            DIV_REM:  div_a = gx_reg;
            DIV_QNUM: div_a = num_reg;
            DIV_QDEN: div_a = den_reg;
            default:  div_a = gx_reg;
        endcase
    end

    rar_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (gy_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Division of the minimum value by minus one wraps
    assign gy_neg_one = &gy_reg;
    assign qn_wrap    = gy_neg_one && (num_reg == W_MIN);
    assign qd_wrap    = gy_neg_one && (den_reg == W_MIN);

    // Hold the wrap flag across the whole transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            wr_reg <= 1'b0;
        end
        else if (((cmd.wr_num || cmd.wr_den) && prod_wrap) ||
                 (cmd.add_go && add_ovf) ||
                 (cmd.num_q && qn_wrap) || (cmd.den_q && qd_wrap))
        begin
            wr_reg <= 1'b1;
        end
    end

    // Capture operands and working values
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= in_data.req_type;
            ln_reg <= WIDTH'(in_data.lhs_num);
            ld_reg <= WIDTH'(in_data.lhs_den);
            rn_reg <= WIDTH'(in_data.rhs_num);
            rd_reg <= WIDTH'(in_data.rhs_den);
        end
        if (cmd.mul_go)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.wr_num)
        begin
            num_reg <= prod_reg[WIDTH-1:0];
        end
        else if (cmd.add_go)
        begin
            num_reg <= sum;
        end
        else if (cmd.num_q)
        begin
            num_reg <= div_q;
        end
        if (cmd.wr_den)
        begin
            den_reg <= prod_reg[WIDTH-1:0];
        end
        else if (cmd.den_q)
        begin
            den_reg <= div_q;
        end
        if (cmd.gcd_init)
        begin
            gx_reg <= num_reg;
            gy_reg <= den_reg;
        end
        else if (cmd.gcd_step)
        begin
            gx_reg <= gy_reg;
            gy_reg <= div_r;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (den_reg == '0)
            begin
                out_reg.res_num <= '0;
                out_reg.res_den <= '0;
                out_reg.status  <= STATUS_UNDEF;
            end
            else
            begin
                out_reg.res_num <= 32'(num_reg);
                out_reg.res_den <= 32'(den_reg);
                out_reg.status  <= wr_reg ? STATUS_WRAP : STATUS_OK;
            end
        end
    end

    assign sts.op       = op_reg;
    assign sts.den_zero = (den_reg == '0);
    assign sts.rem_zero = (div_r == '0);
    assign sts.div_done = div_done;
    assign sts.div_busy = div_busy;
    assign out_data     = out_reg;

endmodule

`default_nettype wire

@@ src/rar_ctrl.sv @@
// Controller: sequences products, Euclid steps, exact quotients and the output.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_reduce_assert.svh"

module rar_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rar_pkg::rar_sts_t sts,
    output rar_pkg::rar_cmd_t      cmd
);
    import rar_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_P1   = 4'd1;
    localparam logic [3:0] S_P1W  = 4'd2;
    localparam logic [3:0] S_P2   = 4'd3;
    localparam logic [3:0] S_P2W  = 4'd4;
    localparam logic [3:0] S_ADD  = 4'd5;
    localparam logic [3:0] S_P3   = 4'd6;
    localparam logic [3:0] S_P3W  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_REM  = 4'd9;
    localparam logic [3:0] S_REMW = 4'd10;
    localparam logic [3:0] S_QN   = 4'd11;
    localparam logic [3:0] S_QNW  = 4'd12;
    localparam logic [3:0] S_QD   = 4'd13;
    localparam logic [3:0] S_QDW  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_addsub;

    assign is_addsub = (sts.op == OP_ADD) || (sts.op == OP_SUB);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_LN_RD;
        cmd.div_sel = DIV_REM;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    pass_next   = 1'b0;
                    state_next  = S_P1;
                end
            end
            S_P1:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = (sts.op == OP_MUL) ? MUL_LN_RN : MUL_LN_RD;
                state_next  = S_P1W;
            end
            S_P1W:
            begin
                cmd.wr_num = 1'b1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.mul_go = 1'b1;
                if (is_addsub)
                begin
                    cmd.mul_sel = MUL_RN_LD;
                end
                else if (sts.op == OP_MUL)
                begin
                    cmd.mul_sel = MUL_LD_RD;
                end
                else
                begin
                    cmd.mul_sel = MUL_LD_RN;
                end
                state_next = S_P2W;
            end
            S_P2W:
            begin
                cmd.wr_den = 1'b1;
                state_next = is_addsub ? S_ADD : S_CHK;
            end
            S_ADD:
            begin
                cmd.add_go = 1'b1;
                state_next = S_P3;
            end
            S_P3:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_LD_RD;
                state_next  = S_P3W;
            end
            S_P3W:
            begin
                cmd.wr_den = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // Zero denominator skips the reduction
                if (sts.den_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_REM;
                end
            end
            S_REM:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_REM;
                state_next    = S_REMW;
            end
            S_REMW:
            begin
                cmd.div_sel = DIV_REM;
                if (sts.div_done)
                begin
                    if (sts.rem_zero)
                    begin
                        state_next = S_QN;
                    end
                    else
                    begin
                        cmd.gcd_step = 1'b1;
                        state_next   = S_REM;
                    end
                end
            end
            S_QN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_QNUM;
                state_next    = S_QNW;
            end
            S_QNW:
            begin
                cmd.div_sel = DIV_QNUM;
                if (sts.div_done)
                begin
                    cmd.num_q  = 1'b1;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_QDEN;
                state_next    = S_QDW;
            end
            S_QDW:
            begin
                cmd.div_sel = DIV_QDEN;
                if (sts.div_done)
                begin
                    cmd.den_q = 1'b1;
                    // Divide reduces a second time
                    if ((sts.op == OP_DIV) && !pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = S_CHK;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track the pending result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `RAR_ASSERT_IMPL(a_div_start_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
    `RAR_ASSERT_IMPL(a_pass_div_only, pass_reg, sts.op == OP_DIV, "second pass on non-divide")
    `RAR_ASSERT_NEXT(a_accept_seq, in_valid && in_ready, (state_reg == S_P1) && !pass_reg, "bad start")
    `RAR_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result overwritten")

endmodule

`default_nettype wire

@@ src/rational_arith_reduce.sv @@
// Top level: signed fraction ALU with gcd reduction.
//
// Input channel in_valid/in_ready/in_data carries one operation and two
// fractions; output channel out_valid/out_ready/out_data returns the reduced
// fraction and a status (ok, wrapped, zero denominator).
// One transaction is in work at a time. Each Euclid remainder step and each
// exact quotient runs on one shared bit-serial divider. Add and subtract use
// three products and multiply two, on a registered 32 x 32 multiplier; divide
// reduces twice. A zero denominator skips reduction.
// The next transaction is accepted in the cycle after the result enters the
// output register, even while the receiver stalls; its result waits until
// that register is taken.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// any pending result.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_reduce (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rar_pkg::rar_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rar_pkg::rar_out_t     out_data
);
    import rar_pkg::*;

    rar_cmd_t cmd;
    rar_sts_t sts;

    // Sequence the transaction
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Compute the fraction
    rar_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
